// ===== rtl/gpi_pkg.sv =====
// Package for the gravity pair impulse block: widths, reset value and the
// stage record type shared by the datapath modules. No dependencies.
package gpi_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 67;   // sum of three 66-bit squares
  localparam int unsigned RootW   = 35;
  localparam int unsigned DenW    = 118;  // s * r * 2^16
  localparam int unsigned ProdW   = 112;  // dt * |k| * ma * mb
  localparam int unsigned NumW    = 144;  // prod * |d|
  localparam int unsigned QuoW    = 33;   // quotient bits kept (saturation beyond)
  localparam logic [31:0] GainRst = 32'h0001_0000;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] dmag;
    logic [SqW-1:0]   sq;
    logic [ProdW-1:0] prod;
  } gpi_ctx_t;

endpackage

// ===== rtl/gpi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side
// record carried alongside. Depends on gpi_pkg.
module gpi_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  gpi_pkg::gpi_ctx_t ctx_i,
  output logic              vld_o,
  output gpi_pkg::gpi_ctx_t ctx_o,
  output logic [gpi_pkg::RootW-1:0] root_o
);
  import gpi_pkg::*;

  logic [RootW:0]          vld_q;
  gpi_ctx_t                ctx_q  [RootW+1];
  logic [RootW-1:0]        root_q [RootW+1];
  logic [SqW+1:0]          rem_q  [RootW+1];

  always_comb begin
    vld_q[0]  = vld_i;
    ctx_q[0]  = ctx_i;
    root_q[0] = '0;
    rem_q[0]  = {2'b00, ctx_i.sq};
  end

  for (genvar g = 0; g < RootW; g++) begin : g_bit
    localparam int B = RootW - 1 - g;
    logic [SqW+1:0]     sub;
    logic               take;
    always_comb begin
      // test (2*root + 2^b) * 2^b against remainder
      sub   = (SqW+2)'(({{(SqW+2-RootW){1'b0}}, root_q[g]} << (B + 1))
              | ((SqW+2)'(1) << (2 * B)));
      take  = rem_q[g] >= sub;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[g+1]  <= ctx_q[g];
        root_q[g+1] <= take ? (root_q[g] | (RootW'(1) << B)) : root_q[g];
        rem_q[g+1]  <= take ? rem_q[g] - sub : rem_q[g];
      end
    end
  end

  assign vld_o  = vld_q[RootW];
  assign ctx_o  = ctx_q[RootW];
  assign root_o = root_q[RootW];
endmodule

// ===== rtl/gpi_div.sv =====
// Pipelined restoring divider for one impulse component: 144-bit numerator
// over 118-bit denominator, keeps 33 quotient bits plus an overflow flag.
// Depends on gpi_pkg.
module gpi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [gpi_pkg::NumW-1:0]  num_i,
  input  logic [gpi_pkg::DenW-1:0]  den_i,
  output logic                      vld_o,
  output logic [gpi_pkg::QuoW-1:0]  quo_o,
  output logic                      big_o
);
  import gpi_pkg::*;

  localparam int unsigned Steps = NumW;
  localparam int unsigned RemW  = DenW + 1;

  logic [Steps:0]    vld_q;
  logic [NumW-1:0]   num_q [Steps+1];
  logic [DenW-1:0]   den_q [Steps+1];
  logic [RemW-1:0]   rem_q [Steps+1];
  logic [QuoW-1:0]   quo_q [Steps+1];
  logic              big_q [Steps+1];

  always_comb begin
    vld_q[0] = vld_i;
    num_q[0] = num_i;
    den_q[0] = den_i;
    rem_q[0] = '0;
    quo_q[0] = '0;
    big_q[0] = 1'b0;
  end

  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic [RemW:0]   sh;
    logic            qb;
    logic [RemW:0]   nrem;
    always_comb begin
      sh   = {rem_q[g], num_q[g][NumW-1]};
      qb   = sh >= {2'b00, den_q[g]};
      nrem = qb ? sh - {2'b00, den_q[g]} : sh;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g+1] <= num_q[g] << 1;
        den_q[g+1] <= den_q[g];
        rem_q[g+1] <= nrem[RemW-1:0];
        quo_q[g+1] <= {quo_q[g][QuoW-2:0], qb};
        big_q[g+1] <= big_q[g] | quo_q[g][QuoW-1];
      end
    end
  end

  assign vld_o = vld_q[Steps];
  assign quo_o = quo_q[Steps];
  assign big_o = big_q[Steps];
endmodule

// ===== rtl/gravity_pair_impulse.sv =====
// Top level of the gravity pair impulse block: differences, squares,
// square root, products and three dividers in one stall-able pipeline.
// Depends on gpi_pkg, gpi_sqrt and gpi_div.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid/in_ready   | pos_a_*_i, pos_b_*_i, mass_*_i, time_step_i
//  out     | out_valid/out_ready | impulse_*_o, fault_o
//  cfg     | cfg_we_i            | cfg_wdata_i (gravity_gain)
//
// One transaction per cycle enters unless stalled. The stages are four front
// stages, the 35-stage root, two stages of 32-bit partial products and their
// sums, the 144-stage bit-per-cycle dividers and the output register. The
// whole pipeline advances when the output register is empty or being taken,
// so a stall freezes every stage. Reset clears valid bits and loads gain 1.0.
module gravity_pair_impulse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] pos_a_z_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  input  logic signed [31:0] pos_b_z_i,
  input  logic [31:0] mass_a_i,
  input  logic [31:0] mass_b_i,
  input  logic [15:0] time_step_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] impulse_x_o,
  output logic signed [31:0] impulse_y_o,
  output logic signed [31:0] impulse_z_o,
  output logic        fault_o
);
  import gpi_pkg::*;

  logic [31:0] gain_q;
  logic        en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainRst;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences and magnitudes, dt*|k|
  logic              v1_q;
  logic [2:0][31:0]  dm1_q;
  logic [2:0]        dneg1_q;
  logic [2:0]        dhi1_q;
  logic [47:0]       dk1_q;
  logic [31:0]       ma1_q, mb1_q;
  logic              kneg;
  logic [31:0]       kmag;
  logic [2:0][DiffW-1:0] dif;
  logic [2:0][DiffW-1:0] dmag;

  assign kneg = gain_q[31];
  assign kmag = kneg ? 32'(-gain_q) : gain_q;

  always_comb begin
    dif[0] = DiffW'({pos_b_x_i[31], pos_b_x_i}) - DiffW'({pos_a_x_i[31], pos_a_x_i});
    dif[1] = DiffW'({pos_b_y_i[31], pos_b_y_i}) - DiffW'({pos_a_y_i[31], pos_a_y_i});
    dif[2] = DiffW'({pos_b_z_i[31], pos_b_z_i}) - DiffW'({pos_a_z_i[31], pos_a_z_i});
    for (int i = 0; i < 3; i++) begin
      dmag[i] = dif[i][DiffW-1] ? DiffW'(-dif[i]) : dif[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dm1_q[i]   <= dmag[i][31:0];
        dhi1_q[i]  <= dmag[i][32];
        dneg1_q[i] <= dif[i][DiffW-1] ^ kneg;
      end
      dk1_q <= 48'(time_step_i) * 48'(kmag);
      ma1_q <= mass_a_i;
      mb1_q <= mass_b_i;
    end
  end

  // stage 2: squares, ma*mb
  logic              v2_q;
  logic [2:0][65:0]  sq2_q;
  logic [2:0][32:0]  dm2_q;
  logic [2:0]        dneg2_q;
  logic [47:0]       dk2_q;
  logic [63:0]       mm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // (h*2^32 + l)^2 with h one bit: l^2 + h*(l<<33) + h*2^64
        sq2_q[i]   <= 66'(64'(dm1_q[i]) * 64'(dm1_q[i]))
                    + (dhi1_q[i] ? (66'(dm1_q[i]) << 33) + (66'(1) << 64) : 66'd0);
        dm2_q[i]   <= {dhi1_q[i], dm1_q[i]};
        dneg2_q[i] <= dneg1_q[i];
      end
      dk2_q <= dk1_q;
      mm2_q <= 64'(ma1_q) * 64'(mb1_q);
    end
  end

  // stage 3: sum of squares, 32-bit partial products of dt*|k| and ma*mb
  logic              v3_q;
  logic [SqW-1:0]    sq3_q;
  logic              zero3_q;
  logic [2:0]        neg3_q;
  logic [2:0][31:0]  dm3_q;
  logic [2:0]        dhi3_q;
  logic [3:0][63:0]  pp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq3_q   <= SqW'(sq2_q[0]) + SqW'(sq2_q[1]) + SqW'(sq2_q[2]);
      zero3_q <= (dm2_q[0] == '0) && (dm2_q[1] == '0) && (dm2_q[2] == '0);
      neg3_q  <= dneg2_q;
      for (int i = 0; i < 3; i++) begin
        dm3_q[i]  <= dm2_q[i][31:0];
        dhi3_q[i] <= dm2_q[i][32];
      end
      pp3_q[0] <= 64'(dk2_q[31:0]) * 64'(mm2_q[31:0]);
      pp3_q[1] <= 64'(dk2_q[31:0]) * 64'(mm2_q[63:32]);
      pp3_q[2] <= 64'(dk2_q[47:32]) * 64'(mm2_q[31:0]);
      pp3_q[3] <= 64'(dk2_q[47:32]) * 64'(mm2_q[63:32]);
    end
  end

  // stage 4: full product from the partials
  logic      v4_q;
  gpi_ctx_t  ctx4_q;
  logic [2:0] dhi4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx4_q <= '{
        zero: zero3_q,
        neg:  neg3_q,
        dmag: dm3_q,
        sq:   sq3_q,
        prod: ProdW'(pp3_q[0]) + (ProdW'(pp3_q[1]) << 32)
              + (ProdW'(pp3_q[2]) << 32) + (ProdW'(pp3_q[3]) << 64)
      };
      dhi4_q <= dhi3_q;
    end
  end

  logic              vr;
  gpi_ctx_t          ctxr;
  logic [RootW-1:0]  root;

  gpi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .ctx_i  (ctx4_q),
    .vld_o  (vr),
    .ctx_o  (ctxr),
    .root_o (root)
  );

  // delay high magnitude bits alongside the root pipeline
  logic [2:0] dhi_dly_q [RootW+1];
  assign dhi_dly_q[0] = dhi4_q;
  for (genvar g = 0; g < RootW; g++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        dhi_dly_q[g+1] <= dhi_dly_q[g];
      end
    end
  end

  // stage 5: 32-bit partial products of denominator and numerators
  logic                      v5_q;
  logic                      zero5_q;
  logic [2:0]                neg5_q;
  logic [5:0][63:0]          dpp5_q;
  logic [2:0][3:0][64:0]     npp5_q;
  logic [2:0][DiffW-1:0]     dfull;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dfull[i] = {dhi_dly_q[RootW][i], ctxr.dmag[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero5_q   <= ctxr.zero;
      neg5_q    <= ctxr.neg;
      dpp5_q[0] <= 64'(ctxr.sq[31:0]) * 64'(root[31:0]);
      dpp5_q[1] <= 64'(ctxr.sq[63:32]) * 64'(root[31:0]);
      dpp5_q[2] <= 64'(ctxr.sq[SqW-1:64]) * 64'(root[31:0]);
      dpp5_q[3] <= 64'(ctxr.sq[31:0]) * 64'(root[RootW-1:32]);
      dpp5_q[4] <= 64'(ctxr.sq[63:32]) * 64'(root[RootW-1:32]);
      dpp5_q[5] <= 64'(ctxr.sq[SqW-1:64]) * 64'(root[RootW-1:32]);
      for (int i = 0; i < 3; i++) begin
        npp5_q[i][0] <= 65'(ctxr.prod[31:0]) * 65'(dfull[i]);
        npp5_q[i][1] <= 65'(ctxr.prod[63:32]) * 65'(dfull[i]);
        npp5_q[i][2] <= 65'(ctxr.prod[95:64]) * 65'(dfull[i]);
        npp5_q[i][3] <= 65'(ctxr.prod[ProdW-1:96]) * 65'(dfull[i]);
      end
    end
  end

  // stage 6: denominator and numerators from the partials
  logic                 v6_q;
  logic                 zero6_q;
  logic [2:0]           neg6_q;
  logic [DenW-1:0]      den6_q;
  logic [2:0][NumW-1:0] num6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero6_q <= zero5_q;
      neg6_q  <= neg5_q;
      den6_q  <= (DenW'(dpp5_q[0]) + (DenW'(dpp5_q[1]) << 32) + (DenW'(dpp5_q[3]) << 32)
                 + (DenW'(dpp5_q[2]) << 64) + (DenW'(dpp5_q[4]) << 64)
                 + (DenW'(dpp5_q[5]) << 96)) << 16;
      for (int i = 0; i < 3; i++) begin
        num6_q[i] <= NumW'(npp5_q[i][0]) + (NumW'(npp5_q[i][1]) << 32)
                   + (NumW'(npp5_q[i][2]) << 64) + (NumW'(npp5_q[i][3]) << 96);
      end
    end
  end

  logic [2:0]            vd;
  logic [2:0][QuoW-1:0]  quo;
  logic [2:0]            big;
  logic [DenW-1:0]       den_safe;
  assign den_safe = zero6_q ? DenW'(1) : den6_q;

  for (genvar c = 0; c < 3; c++) begin : g_div
    gpi_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v6_q),
      .num_i  (num6_q[c]),
      .den_i  (den_safe),
      .vld_o  (vd[c]),
      .quo_o  (quo[c]),
      .big_o  (big[c])
    );
  end

  // carry sign and zero flags beside the dividers
  localparam int unsigned DivLat = NumW;
  logic [3:0] side_q [DivLat+1];
  assign side_q[0] = {zero6_q, neg6_q};
  for (genvar g = 0; g < DivLat; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // output register: saturate and sign
  logic [2:0][31:0] res;
  logic             flt;
  logic             zf;
  always_comb begin
    zf  = side_q[DivLat][3];
    flt = zf;
    for (int i = 0; i < 3; i++) begin
      if (zf) begin
        res[i] = '0;
      end else if (side_q[DivLat][i]) begin
        if (big[i] || quo[i] > QuoW'(32'h8000_0000)) begin
          res[i] = 32'h8000_0000;
          flt    = 1'b1;
        end else begin
          res[i] = 32'(-quo[i]);
        end
      end else begin
        if (big[i] || quo[i] > QuoW'(32'h7FFF_FFFF)) begin
          res[i] = 32'h7FFF_FFFF;
          flt    = 1'b1;
        end else begin
          res[i] = quo[i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      impulse_x_o <= res[0];
      impulse_y_o <= res[1];
      impulse_z_o <= res[2];
      fault_o     <= flt;
    end
  end

  logic unused_vd;
  assign unused_vd = vd[1] ^ vd[2];
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for gravity_pair_impulse: directed table plus random body pairs,
// checked against a wide-integer model of the impulse path. Needs the RTL only.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] ax, ay, az, bx, by, bz;
    logic [31:0] ma, mb;
    logic [15:0] dt;
  } pair_t;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        fault;
  } impulse_t;

  typedef struct packed {
    pair_t    pair;
    logic     known;
    impulse_t res;
  } row_t;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainCycles  = 250;
  localparam int unsigned WatchdogMax  = 20000;
  localparam int unsigned RandPerGain  = 147;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] pos_a_x_i = '0, pos_a_y_i = '0, pos_a_z_i = '0;
  logic [31:0] pos_b_x_i = '0, pos_b_y_i = '0, pos_b_z_i = '0;
  logic [31:0] mass_a_i = '0, mass_b_i = '0;
  logic [15:0] time_step_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] impulse_x_o, impulse_y_o, impulse_z_o;
  logic        fault_o;

  gravity_pair_impulse dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid, .in_ready,
    .pos_a_x_i, .pos_a_y_i, .pos_a_z_i, .pos_b_x_i, .pos_b_y_i, .pos_b_z_i,
    .mass_a_i, .mass_b_i, .time_step_i,
    .out_valid, .out_ready,
    .impulse_x_o, .impulse_y_o, .impulse_z_o, .fault_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  logic [31:0] gain_q = gpi_pkg::GainRst;
  impulse_t    pending_impulses[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic impulse_t gravity_impulse(pair_t p, logic [31:0] gain);
    logic signed [33:0] d [3];
    logic [32:0]  dmag [3];
    logic [66:0]  sumsq;
    logic [34:0]  root, cand;
    logic [69:0]  csq;
    logic [117:0] den;
    logic [111:0] prod;
    logic [143:0] num, quo;
    logic [31:0]  kmag, comp [3];
    logic         negc, fault;
    impulse_t     r;
    d[0] = $signed({{2{p.bx[31]}}, p.bx}) - $signed({{2{p.ax[31]}}, p.ax});
    d[1] = $signed({{2{p.by[31]}}, p.by}) - $signed({{2{p.ay[31]}}, p.ay});
    d[2] = $signed({{2{p.bz[31]}}, p.bz}) - $signed({{2{p.az[31]}}, p.az});
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      dmag[i] = d[i][33] ? 33'(-d[i]) : 33'(d[i]);
      sumsq += 67'(dmag[i]) * 67'(dmag[i]);
    end
    if (sumsq == '0) begin
      r = '{x: '0, y: '0, z: '0, fault: 1'b1};
      return r;
    end
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (35'd1 << b);
      csq = 70'(cand) * 70'(cand);
      if (csq <= 70'(sumsq)) root = cand;
    end
    den = (118'(sumsq) * 118'(root)) << 16;
    kmag = gain[31] ? 32'(-gain) : gain;
    prod = 112'(p.dt) * 112'(kmag) * 112'(p.ma) * 112'(p.mb);
    fault = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = 144'(prod) * 144'(dmag[i]);
      quo = num / 144'(den);
      negc = gain[31] != d[i][33];
      if (negc) begin
        if (quo > 144'h8000_0000) begin
          comp[i] = 32'h8000_0000;
          fault = 1'b1;
        end else begin
          comp[i] = 32'(-quo[31:0]);
        end
      end else if (quo > 144'h7FFF_FFFF) begin
        comp[i] = 32'h7FFF_FFFF;
        fault = 1'b1;
      end else begin
        comp[i] = quo[31:0];
      end
    end
    r = '{x: comp[0], y: comp[1], z: comp[2], fault: fault};
    return r;
  endfunction

  // Offer one pair, optionally after a short gap, and hold it until taken.
  task automatic send_pair(pair_t p, bit has_known, impulse_t known);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    {pos_a_x_i, pos_a_y_i, pos_a_z_i} = {p.ax, p.ay, p.az};
    {pos_b_x_i, pos_b_y_i, pos_b_z_i} = {p.bx, p.by, p.bz};
    {mass_a_i, mass_b_i, time_step_i} = {p.ma, p.mb, p.dt};
    in_valid = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_valid && in_ready) break;
    end
    pending_impulses.push_back(has_known ? known : gravity_impulse(p, gain_q));
    @(negedge clk_i);
  endtask

  task automatic write_gain(logic [31:0] g);
    in_valid = 1'b0;
    wait (pending_impulses.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = g;
    gain_q = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    logic [31:0] spread;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, 16'($urandom)};
    case ($urandom_range(0, 9))
      0, 1: ; // full-range noise
      2: begin
        p.bx = p.ax; p.by = p.ay; p.bz = p.az;
      end
      default: begin
        // nearby bodies with moderate masses give in-range impulses
        spread = 32'd1 << $urandom_range(4, 24);
        p.bx = p.ax + ($urandom % spread) - spread / 2;
        p.by = p.ay + ($urandom % spread) - spread / 2;
        p.bz = p.az + ($urandom % spread) - spread / 2;
        p.ma = p.ma >> $urandom_range(0, 31);
        p.mb = p.mb >> $urandom_range(0, 31);
      end
    endcase
    return p;
  endfunction

  // Receiver: random stalls, one long hold on request, none once quiet.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    impulse_t want;
    if (out_valid && out_ready) begin
      if (pending_impulses.size() == 0) begin
        $error("impulse with no pending transaction");
        errors++;
      end else begin
        want = pending_impulses.pop_front();
        if (impulse_x_o !== want.x) begin
          $error("impulse_x expected %h got %h", want.x, impulse_x_o);
          errors++;
        end
        if (impulse_y_o !== want.y) begin
          $error("impulse_y expected %h got %h", want.y, impulse_y_o);
          errors++;
        end
        if (impulse_z_o !== want.z) begin
          $error("impulse_z expected %h got %h", want.z, impulse_z_o);
          errors++;
        end
        if (fault_o !== want.fault) begin
          $error("fault expected %b got %b", want.fault, fault_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogMax) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] Max = 32'hFFFF_FFFF;
  localparam logic [31:0] Lo  = 32'h8000_0000;
  localparam logic [31:0] Hi  = 32'h7FFF_FFFF;

  row_t directed [] = '{
    '{'{0, 0, 0, 0, 0, 0, One, One, 16'hFFFF}, 1'b1, '{0, 0, 0, 1'b1}},
    '{'{Lo, Hi, Lo, Lo, Hi, Lo, Max, Max, 16'hFFFF}, 1'b1, '{0, 0, 0, 1'b1}},
    '{'{0, 0, 0, One, 0, 0, One, One, 16'h0000}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{0, 0, 0, One, One, 0, 0, One, 16'h8000}, 1'b1, '{0, 0, 0, 1'b0}},
    '{'{0, 0, 0, 0, 0, 1, Max, Max, 16'hFFFF}, 1'b1, '{0, 0, Hi, 1'b1}},
    '{'{1, 0, 0, 0, 0, 0, Max, Max, 16'hFFFF}, 1'b1, '{Lo, 0, 0, 1'b1}},
    '{'{0, 0, 0, One, 0, 0, One, One, 16'hFFFF}, 1'b0, '0},
    '{'{0, 0, 0, 0, -One, 0, One, One, 16'h0001}, 1'b0, '0},
    '{'{Lo, Lo, Lo, Hi, Hi, Hi, Max, Max, 16'hFFFF}, 1'b0, '0},
    '{'{Hi, Hi, Hi, Lo, Lo, Lo, Max, Max, 16'hFFFF}, 1'b0, '0},
    '{'{One, 2 * One, 3 * One, -One, 5 * One, 0, 32'h0100_0000, 32'h0040_0000, 16'h4000},
      1'b0, '0},
    '{'{0, 0, 0, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, One, One, 16'h0100}, 1'b0, '0},
    '{'{0, 0, 0, 32'h0064_0000, 0, 0, 32'h0001_8000, 32'h0000_4000, 16'hFFFF}, 1'b0, '0}
  };

  logic [31:0] gains [] = '{Hi, Lo, 32'hFFFF_0000, 32'h0000_0001, 32'h0000_0000,
                            32'h0123_4567, 32'hFEDC_BA98};

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_pair(directed[i].pair, directed[i].known, directed[i].res);
    write_gain(One);
    foreach (directed[i]) send_pair(directed[i].pair, 1'b0, '0);
    for (int g = 0; g <= gains.size(); g++) begin
      if (g > 0) write_gain(gains[g - 1]);
      if (g == gains.size()) begin
        write_gain($urandom);
        quiet = 1'b1;
      end
      if (g == 2) hold_req = 1'b1;
      for (int n = 0; n < RandPerGain; n++) send_pair(rand_pair(), 1'b0, '0);
    end
    in_valid = 1'b0;
    wait (pending_impulses.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
